FILE: rtl/core/mm3_pkg.sv
// Shared types and constants for the 128-bit murmur3 hash block.
package mm3_pkg;

  // Mixing constants
  localparam logic [63:0] MUL_A   = 64'h87C37B91114253D5;
  localparam logic [63:0] MUL_B   = 64'h4CF5AD432745937F;
  localparam logic [63:0] FIN_A   = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] FIN_B   = 64'hC4CEB9FE1A85EC53;
  localparam logic [63:0] ADD_ONE = 64'h0000000052DCE729;
  localparam logic [63:0] ADD_TWO = 64'h0000000038495AB5;

  localparam int unsigned ROT_K1   = 31;
  localparam int unsigned ROT_K2   = 33;
  localparam int unsigned ROT_H1   = 27;
  localparam int unsigned ROT_H2   = 31;
  localparam int unsigned FMIX_SHR = 33;

  localparam logic [3:0] BYTES_PER_WORD = 4'd8;

  // Command queue between front and back (power-of-two depth, pointers wrap)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Last partial-product step of the shared multiplier
  localparam logic [1:0] MUL_LAST_STEP = 2'd3;

  // One unit of work for the back end
  typedef struct packed {
    logic [63:0] k1;
    logic [63:0] k2;
    logic [63:0] length;
    logic        is_final;
    logic        is_block;
    logic        use_k1;
    logic        use_k2;
  } mm3_cmd_t;

  // Multiplier request / response
  typedef struct packed {
    logic        start;
    logic [63:0] operand;
    logic [63:0] factor;
  } mm3_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mm3_mul_rsp_t;

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

endpackage

FILE: rtl/core/mm3_if.sv
// Message word channel
interface mm3_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last,
                  output ready);
endinterface

// Digest channel
interface mm3_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;

  modport source (output valid, output digest_low, output digest_high, input ready);
  modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

FILE: rtl/core/mm3_mul.sv
// 64x64 multiply, low 64 bits, over one shared 32x32 multiplier.
// Three partial products, each registered before accumulation.
module mm3_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mm3_pkg::mm3_mul_req_t req_i,
  output mm3_pkg::mm3_mul_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [1:0]  step_q, step_d;
  logic [63:0] x_q, x_d;
  logic [63:0] c_q, c_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] mul_a, mul_b;

  // Partial product select: lo*lo, lo*hi, hi*lo
  always_comb begin
    case (step_q)
      2'd0: begin
        mul_a = x_q[31:0];
        mul_b = c_q[31:0];
      end
      2'd1: begin
        mul_a = x_q[31:0];
        mul_b = c_q[63:32];
      end
      2'd2: begin
        mul_a = x_q[63:32];
        mul_b = c_q[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Step control and accumulation
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    x_d    = x_q;
    c_d    = c_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      x_d    = req_i.operand;
      c_d    = req_i.factor;
    end else if (busy_q) begin
      prod_d = 64'(mul_a) * 64'(mul_b);
      step_d = step_q + 2'd1;
      if (step_q == 2'd1) begin
        acc_d = prod_q;
      end else if (step_q != 2'd0) begin
        acc_d = acc_q + {prod_q[31:0], 32'd0};
      end
      if (step_q == mm3_pkg::MUL_LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    c_q    <= c_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

FILE: rtl/core/mm3_back.sv
// Back end: premixes the block words, updates the lanes, finalizes.
module mm3_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  mm3_pkg::mm3_cmd_t q_head_i,
  output logic              q_pop_o,
  mm3_out_if.source         out_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PA1  = 5'd1;
  localparam logic [4:0] S_PA2  = 5'd2;
  localparam logic [4:0] S_PB1  = 5'd3;
  localparam logic [4:0] S_PB2  = 5'd4;
  localparam logic [4:0] S_C1   = 5'd5;
  localparam logic [4:0] S_C2   = 5'd6;
  localparam logic [4:0] S_C3   = 5'd7;
  localparam logic [4:0] S_C4   = 5'd8;
  localparam logic [4:0] S_TAIL = 5'd9;
  localparam logic [4:0] S_F1   = 5'd10;
  localparam logic [4:0] S_F2   = 5'd11;
  localparam logic [4:0] S_F3   = 5'd12;
  localparam logic [4:0] S_F4   = 5'd13;
  localparam logic [4:0] S_FA1  = 5'd14;
  localparam logic [4:0] S_FA2  = 5'd15;
  localparam logic [4:0] S_FB1  = 5'd16;
  localparam logic [4:0] S_FB2  = 5'd17;
  localparam logic [4:0] S_F5   = 5'd18;
  localparam logic [4:0] S_F6   = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  logic [4:0]            state_q, state_d;
  mm3_pkg::mm3_cmd_t     cmd_q, cmd_d;
  logic [63:0]           a_q, a_d;
  logic [63:0]           b_q, b_d;
  logic [63:0]           f_q, f_d;
  logic [63:0]           s_q, s_d;
  logic                  pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  logic [63:0]           dig_lo_q, dig_lo_d;
  logic [63:0]           dig_hi_q, dig_hi_d;
  logic                  mul_state;
  logic                  mul_start;
  logic [63:0]           prod;
  mm3_pkg::mm3_mul_req_t mreq;
  mm3_pkg::mm3_mul_rsp_t mrsp;

  mm3_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign prod = mrsp.product;

  // Multiply states issue one request and wait for its result
  assign mul_state = (state_q == S_PA1) || (state_q == S_PA2) || (state_q == S_PB1) ||
                     (state_q == S_PB2) || (state_q == S_FA1) || (state_q == S_FA2) ||
                     (state_q == S_FB1) || (state_q == S_FB2);

  always_comb begin
    mul_start = mul_state && !pend_q;
    pend_d    = pend_q;
    if (mul_start) begin
      pend_d = 1'b1;
    end else if (mrsp.done) begin
      pend_d = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    a_d          = a_q;
    b_d          = b_q;
    f_d          = f_q;
    s_d          = s_q;
    dig_lo_d     = dig_lo_q;
    dig_hi_d     = dig_hi_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    q_pop_o      = 1'b0;
    mreq.start   = mul_start;
    mreq.operand = a_q;
    mreq.factor  = mm3_pkg::MUL_A;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_head_i;
          a_d     = q_head_i.k1;
          b_d     = q_head_i.k2;
          state_d = S_PA1;
        end
      end
      S_PA1: begin
        mreq.factor = mm3_pkg::MUL_A;
        if (mrsp.done) begin
          a_d     = mm3_pkg::rotl64(prod, mm3_pkg::ROT_K1);
          state_d = S_PA2;
        end
      end
      S_PA2: begin
        mreq.factor = mm3_pkg::MUL_B;
        if (mrsp.done) begin
          a_d     = prod;
          state_d = S_PB1;
        end
      end
      S_PB1: begin
        mreq.operand = b_q;
        mreq.factor  = mm3_pkg::MUL_B;
        if (mrsp.done) begin
          b_d     = mm3_pkg::rotl64(prod, mm3_pkg::ROT_K2);
          state_d = S_PB2;
        end
      end
      S_PB2: begin
        mreq.operand = b_q;
        mreq.factor  = mm3_pkg::MUL_A;
        if (mrsp.done) begin
          b_d     = prod;
          state_d = cmd_q.is_block ? S_C1 : S_TAIL;
        end
      end
      // Full block lane update
      S_C1: begin
        f_d     = mm3_pkg::rotl64(f_q ^ a_q, mm3_pkg::ROT_H1) + s_q;
        state_d = S_C2;
      end
      S_C2: begin
        f_d     = (f_q << 2) + f_q + mm3_pkg::ADD_ONE;
        state_d = S_C3;
      end
      S_C3: begin
        s_d     = mm3_pkg::rotl64(s_q ^ b_q, mm3_pkg::ROT_H2) + f_q;
        state_d = S_C4;
      end
      S_C4: begin
        s_d     = (s_q << 2) + s_q + mm3_pkg::ADD_TWO;
        state_d = cmd_q.is_final ? S_F1 : S_IDLE;
      end
      // Partial tail: xor only
      S_TAIL: begin
        if (cmd_q.use_k2) begin
          s_d = s_q ^ b_q;
        end
        if (cmd_q.use_k1) begin
          f_d = f_q ^ a_q;
        end
        state_d = S_F1;
      end
      // Finalization
      S_F1: begin
        a_d     = f_q ^ cmd_q.length;
        b_d     = s_q ^ cmd_q.length;
        state_d = S_F2;
      end
      S_F2: begin
        a_d     = a_q + b_q;
        state_d = S_F3;
      end
      S_F3: begin
        b_d     = b_q + a_q;
        state_d = S_F4;
      end
      S_F4: begin
        a_d     = a_q ^ (a_q >> mm3_pkg::FMIX_SHR);
        b_d     = b_q ^ (b_q >> mm3_pkg::FMIX_SHR);
        state_d = S_FA1;
      end
      S_FA1: begin
        mreq.factor = mm3_pkg::FIN_A;
        if (mrsp.done) begin
          a_d     = prod ^ (prod >> mm3_pkg::FMIX_SHR);
          state_d = S_FA2;
        end
      end
      S_FA2: begin
        mreq.factor = mm3_pkg::FIN_B;
        if (mrsp.done) begin
          a_d     = prod ^ (prod >> mm3_pkg::FMIX_SHR);
          state_d = S_FB1;
        end
      end
      S_FB1: begin
        mreq.operand = b_q;
        mreq.factor  = mm3_pkg::FIN_A;
        if (mrsp.done) begin
          b_d     = prod ^ (prod >> mm3_pkg::FMIX_SHR);
          state_d = S_FB2;
        end
      end
      S_FB2: begin
        mreq.operand = b_q;
        mreq.factor  = mm3_pkg::FIN_B;
        if (mrsp.done) begin
          b_d     = prod ^ (prod >> mm3_pkg::FMIX_SHR);
          state_d = S_F5;
        end
      end
      S_F5: begin
        a_d     = a_q + b_q;
        state_d = S_F6;
      end
      S_F6: begin
        b_d     = b_q + a_q;
        state_d = S_OUT;
      end
      // Load the output register once it is free, restart the lanes
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          dig_lo_d    = a_q;
          dig_hi_d    = b_q;
          out_valid_d = 1'b1;
          f_d         = '0;
          s_d         = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      f_q         <= '0;
      s_q         <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      f_q         <= f_d;
      s_q         <= s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    a_q      <= a_d;
    b_q      <= b_d;
    dig_lo_q <= dig_lo_d;
    dig_hi_q <= dig_hi_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_low  = dig_lo_q;
  assign out_o.digest_high = dig_hi_q;

  // A multiplier result only arrives for an outstanding request
  assert property (@(posedge clk_i) disable iff (!rst_ni) mrsp.done |-> pend_q)
    else $error("multiplier result without request");

  // Delivering a digest leaves clean lanes and a pending output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && state_d == S_IDLE) |=> (f_q == '0 && s_q == '0 && out_valid_q))
    else $error("lanes not cleared after digest");

endmodule

FILE: rtl/core/mm3_fifo.sv
// Short command queue between front and back.
module mm3_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mm3_pkg::mm3_cmd_t push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output mm3_pkg::mm3_cmd_t head_o,
  output logic              empty_o
);

  mm3_pkg::mm3_cmd_t               mem_q [mm3_pkg::QUEUE_DEPTH];
  logic [mm3_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mm3_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mm3_pkg::QUEUE_AW:0]      count_q, count_d;

  assign full_o  = (count_q == (mm3_pkg::QUEUE_AW + 1)'(mm3_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + (mm3_pkg::QUEUE_AW)'(push_i);
    rd_ptr_d = rd_ptr_q + (mm3_pkg::QUEUE_AW)'(pop_i);
    count_d  = count_q + (mm3_pkg::QUEUE_AW + 1)'(push_i)
                       - (mm3_pkg::QUEUE_AW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty command queue");

endmodule

FILE: rtl/core/mm3_front.sv
// Front end: pairs words into blocks, masks the last word, counts bytes.
module mm3_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  mm3_in_if.sink            in_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output mm3_pkg::mm3_cmd_t q_cmd_o
);

  logic        held_q, held_d;
  logic [63:0] held_word_q, held_word_d;
  logic [63:0] len_q, len_d;
  logic        accept;
  logic [3:0]  nb;
  logic [63:0] masked;
  logic [63:0] len_sum;
  logic        full_word;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // Clamp byte count and zero the bytes past it
  always_comb begin
    nb = (in_i.byte_count > mm3_pkg::BYTES_PER_WORD) ? mm3_pkg::BYTES_PER_WORD
                                                     : in_i.byte_count;
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (4'(i) < nb) ? in_i.data_word[i*8 +: 8] : 8'd0;
    end
    full_word = (nb == mm3_pkg::BYTES_PER_WORD);
    len_sum   = len_q + 64'(nb);
  end

  // Command build: a block on the second word of a pair, a final on last
  always_comb begin
    q_push_o         = accept && (in_i.last || held_q);
    q_cmd_o.length   = len_sum;
    if (in_i.last) begin
      q_cmd_o.is_final = 1'b1;
      q_cmd_o.is_block = held_q && full_word;
      q_cmd_o.k1       = held_q ? held_word_q : masked;
      q_cmd_o.k2       = masked;
      q_cmd_o.use_k1   = held_q || (nb != 4'd0);
      q_cmd_o.use_k2   = held_q && (nb != 4'd0);
    end else begin
      q_cmd_o.is_final = 1'b0;
      q_cmd_o.is_block = 1'b1;
      q_cmd_o.k1       = held_word_q;
      q_cmd_o.k2       = in_i.data_word;
      q_cmd_o.use_k1   = 1'b1;
      q_cmd_o.use_k2   = 1'b1;
    end
  end

  // Pairing and length state
  always_comb begin
    held_d      = held_q;
    held_word_d = held_word_q;
    len_d       = len_q;
    if (accept) begin
      if (in_i.last) begin
        held_d = 1'b0;
        len_d  = '0;
      end else begin
        len_d  = len_q + 64'(mm3_pkg::BYTES_PER_WORD);
        held_d = !held_q;
        if (!held_q) begin
          held_word_d = in_i.data_word;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      len_q  <= '0;
    end else begin
      held_q <= held_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_word_q <= held_word_d;
  end

endmodule

FILE: rtl/core/murmur3_x64_128_hash.sv
// Channel   Direction  Payload                        Transaction
// in_i      sink       data_word, byte_count, last    one message word
// out_o     source     digest_low, digest_high        one 128-bit digest
//
// Every 64-bit multiply runs on one shared 32x32 multiplier.
// A pair of full words costs four multiplies and the lane update in the back
// end; the last word costs four premix and four finalizer multiplies. The
// front accepts words while the two-entry command queue has room, so input
// runs ahead of the back end; a waiting digest blocks only the next digest.
// Reset clears the lanes, pairing and length state at once.
module murmur3_x64_128_hash (
  input  logic       clk_i,
  input  logic       rst_ni,
  mm3_in_if.sink     in_i,
  mm3_out_if.source  out_o
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  mm3_pkg::mm3_cmd_t q_cmd;
  mm3_pkg::mm3_cmd_t q_head;

  mm3_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd)
  );

  mm3_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  mm3_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
